### sv/lcts_pkg.sv
// ----------------------------------------------------------------------------
// lcts_pkg
// Shared widths, codes and control types for the load-cell tare/scale core.
// ----------------------------------------------------------------------------
package lcts_pkg;

  localparam int RAW_W       = 24;  // converter word
  localparam int DIFF_W      = 25;  // difference of two readings
  localparam int MASS_W      = 24;  // reference mass register
  localparam int PROD_W      = 50;  // signed difference times mass
  localparam int WEIGHT_W    = 49;  // weight output
  localparam int SUM_W       = 31;  // running sum of samples
  localparam int CNT_W       = 7;   // running sample count
  localparam int AVG_SAMPLES = 10;  // samples per tare/reference average
  localparam int DIVD_W      = 49;  // divider dividend magnitude
  localparam int DIVS_W      = 25;  // divider divisor magnitude
  localparam int DIV_CNT_W   = 6;   // holds DIVD_W

  // mode codes on the input
  localparam logic [1:0] MODE_MEASURE = 2'd0;
  localparam logic [1:0] MODE_TARE    = 2'd1;
  localparam logic [1:0] MODE_REF     = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd0;  // no average running

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_CAL   = 2'd1,
    STATUS_UNCAL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_CHECK,
    S_MUL,
    S_DIV_START,
    S_DIV_WAIT,
    S_DONE
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch the input request
    logic prep;       // accumulate or form differences
    logic mul;        // register the product
    logic div_start;  // load the serial divider
    logic finish;     // commit state, load the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_cal;     // request is a tare or reference sample
    logic avg_full;   // average has its last sample
    logic div_zero;   // reference equals zero offset
    logic div_busy;   // serial divider running
    logic out_free;   // output register can take a result
  } dp_sts_t;

endpackage

### sv/lcts_div.sv
// ----------------------------------------------------------------------------
// lcts_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcts_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lcts_pkg::DIVD_W-1:0] dividend_i,
  input  logic [lcts_pkg::DIVS_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic [lcts_pkg::DIVD_W-1:0] quotient_o
);
  import lcts_pkg::*;

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIVD_W-1:0]    quo_q, quo_d;
  logic [DIVS_W-1:0]    rem_q, rem_d;
  logic [DIVS_W-1:0]    dvs_q, dvs_d;
  logic [DIVS_W:0]      shifted;
  logic [DIVS_W:0]      diff;

  assign shifted = {rem_q, quo_q[DIVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIVD_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[DIVS_W]) begin
        rem_d = diff[DIVS_W-1:0];
        quo_d = {quo_q[DIVD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DIVS_W-1:0];
        quo_d = {quo_q[DIVD_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      busy_d = (cnt_q != DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

### sv/lcts_datapath.sv
// ----------------------------------------------------------------------------
// lcts_datapath
// Calibration state, averaging, multiply, shared divider and output register.
// ----------------------------------------------------------------------------
module lcts_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lcts_pkg::dp_cmd_t           cmd_i,
  output lcts_pkg::dp_sts_t           sts_o,
  input  logic                        cfg_wr_i,
  input  logic [lcts_pkg::MASS_W-1:0] cfg_data_i,
  output logic [lcts_pkg::MASS_W-1:0] ref_mass_o,
  input  logic [1:0]                  in_mode_i,
  input  logic [lcts_pkg::RAW_W-1:0]  in_raw_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lcts_pkg::RAW_W-1:0]  out_raw_o,
  output logic [lcts_pkg::WEIGHT_W-1:0] out_weight_o,
  output logic                        out_wvalid_o,
  output lcts_pkg::status_e           out_status_o,
  output logic                        out_done_o
);
  import lcts_pkg::*;

  // configuration and calibration state
  logic [MASS_W-1:0]        ref_mass_q;
  logic signed [RAW_W-1:0]  zero_q;
  logic signed [RAW_W-1:0]  refr_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [1:0]               avg_mode_q;

  // per-request working registers
  logic [1:0]               mode_q;
  logic signed [RAW_W-1:0]  raw_q;
  logic signed [DIFF_W-1:0] num_q;
  logic signed [DIFF_W-1:0] den_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     neg_q;

  // output register
  logic                     out_valid_q;
  logic [RAW_W-1:0]         out_raw_q;
  logic [WEIGHT_W-1:0]      out_weight_q;
  logic                     out_wvalid_q;
  status_e                  out_status_q;
  logic                     out_done_q;

  logic                     is_cal;
  logic                     avg_full;
  logic                     div_zero;
  logic signed [SUM_W-1:0]  raw_ext;
  logic [PROD_W-1:0]        prod_mag;
  logic [SUM_W-1:0]         sum_mag;
  logic [DIFF_W-1:0]        den_mag;
  logic [DIVD_W-1:0]        div_dividend;
  logic [DIVS_W-1:0]        div_divisor;
  logic                     div_busy;
  logic [DIVD_W-1:0]        quo;
  logic [DIVD_W-1:0]        quo_signed;

  assign is_cal   = (mode_q == MODE_TARE) || (mode_q == MODE_REF);
  assign avg_full = (cnt_q >= CNT_W'(AVG_SAMPLES));
  assign div_zero = (den_q == '0);
  assign raw_ext  = {{(SUM_W-RAW_W){raw_q[RAW_W-1]}}, raw_q};

  assign prod_mag = prod_q[PROD_W-1] ? (~prod_q + 1'b1) : prod_q;
  assign sum_mag  = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
  assign den_mag  = den_q[DIFF_W-1] ? (~den_q + 1'b1) : den_q;

  // the divider is shared: average by the sample count, or weight by span
  always_comb begin
    if (is_cal) begin
      div_dividend = {{(DIVD_W-SUM_W){1'b0}}, sum_mag};
      div_divisor  = DIVS_W'(AVG_SAMPLES);
    end else begin
      div_dividend = prod_mag[DIVD_W-1:0];
      div_divisor  = den_mag;
    end
  end

  lcts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  assign quo_signed = neg_q ? (~quo + 1'b1) : quo;

  // control-like state: calibration values, average bookkeeping, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_mass_q  <= '0;
      zero_q      <= '0;
      refr_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      avg_mode_q  <= MODE_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_i) begin
        ref_mass_q <= cfg_data_i;
      end
      if (cmd_i.prep) begin
        if (!is_cal) begin
          sum_q      <= '0;
          cnt_q      <= '0;
          avg_mode_q <= MODE_NONE;
        end else if (avg_mode_q != mode_q) begin
          sum_q      <= raw_ext;
          cnt_q      <= CNT_W'(1);
          avg_mode_q <= mode_q;
        end else begin
          sum_q <= sum_q + raw_ext;
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      if (cmd_i.finish && is_cal && avg_full) begin
        if (mode_q == MODE_TARE) begin
          zero_q <= quo_signed[RAW_W-1:0];
        end else begin
          refr_q <= quo_signed[RAW_W-1:0];
        end
        sum_q      <= '0;
        cnt_q      <= '0;
        avg_mode_q <= MODE_NONE;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= in_mode_i;
      raw_q  <= in_raw_i;
    end
    if (cmd_i.prep) begin
      num_q <= {raw_q[RAW_W-1], raw_q} - {zero_q[RAW_W-1], zero_q};
      den_q <= {refr_q[RAW_W-1], refr_q} - {zero_q[RAW_W-1], zero_q};
    end
    if (cmd_i.mul) begin
      prod_q <= num_q * $signed({1'b0, ref_mass_q});
    end
    if (cmd_i.div_start) begin
      neg_q <= is_cal ? sum_q[SUM_W-1] : (prod_q[PROD_W-1] ^ den_q[DIFF_W-1]);
    end
    if (cmd_i.finish) begin
      out_raw_q    <= raw_q;
      out_weight_q <= '0;
      out_wvalid_q <= 1'b0;
      out_done_q   <= 1'b0;
      if (is_cal) begin
        if (avg_full) begin
          out_status_q <= STATUS_OK;
          out_done_q   <= 1'b1;
        end else begin
          out_status_q <= STATUS_CAL;
        end
      end else if (div_zero) begin
        out_status_q <= STATUS_UNCAL;
      end else begin
        out_status_q <= STATUS_OK;
        out_weight_q <= quo_signed;
        out_wvalid_q <= 1'b1;
      end
    end
  end

  assign sts_o.is_cal   = is_cal;
  assign sts_o.avg_full = avg_full;
  assign sts_o.div_zero = div_zero;
  assign sts_o.div_busy = div_busy;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign ref_mass_o   = ref_mass_q;
  assign out_valid_o  = out_valid_q;
  assign out_raw_o    = out_raw_q;
  assign out_weight_o = out_weight_q;
  assign out_wvalid_o = out_wvalid_q;
  assign out_status_o = out_status_q;
  assign out_done_o   = out_done_q;

endmodule

### sv/lcts_ctrl.sv
// ----------------------------------------------------------------------------
// lcts_ctrl
// Sequencer: one request at a time through accumulate, multiply and divide.
// ----------------------------------------------------------------------------
module lcts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lcts_pkg::dp_sts_t sts_i,
  output lcts_pkg::dp_cmd_t cmd_o
);
  import lcts_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.is_cal) begin
          state_d = sts_i.avg_full ? S_DIV_START : S_DONE;
        end else begin
          state_d = sts_i.div_zero ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV_START;
      end
      S_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### sv/load_cell_tare_scale_core.sv
// ----------------------------------------------------------------------------
// load_cell_tare_scale_core
// Load-cell front end: takes 24-bit converter words with a mode on a stream
// input. Tare and reference requests build a running average of AVG_SAMPLES
// words (a change of mode restarts it) and store the truncated mean as the
// zero offset or the reference reading. Measure requests return
// (raw - offset) * ref_mass_mg / (reference - offset) in mg, truncated toward
// zero, or status "uncalibrated" with weight 0 when reference equals offset.
// Every request gives exactly one result. Requests are handled one at a time:
// a measure request goes through a multiply step and then the 49-step
// bit-serial divider; a calibration request that closes an average uses the
// same divider; other calibration requests and zero-divisor measures skip
// both. A finished result waits in the output register while the next request
// is accepted. ref_mass_mg sits at APB address 0 and must be written only
// while the core is idle.
// ----------------------------------------------------------------------------
module load_cell_tare_scale_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] raw_code
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [23:0] signed_raw, [72:24] weight_mg, zero pad
  output logic [3:0]  m_axis_tuser,   // [0] weight_valid, [2:1] status, [3] cal_done
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lcts_pkg::*;

  dp_cmd_t              cmd;
  dp_sts_t              sts;
  logic                 cfg_wr;
  logic [MASS_W-1:0]    ref_mass;
  logic [RAW_W-1:0]     out_raw;
  logic [WEIGHT_W-1:0]  out_weight;
  logic                 out_wvalid;
  status_e              out_status;
  logic                 out_done;

  // APB: zero-wait, single register at word 0
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {{(32-MASS_W){1'b0}}, ref_mass};

  lcts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lcts_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_wr_i     (cfg_wr),
    .cfg_data_i   (pwdata[MASS_W-1:0]),
    .ref_mass_o   (ref_mass),
    .in_mode_i    (s_axis_tuser),
    .in_raw_i     (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_raw_o    (out_raw),
    .out_weight_o (out_weight),
    .out_wvalid_o (out_wvalid),
    .out_status_o (out_status),
    .out_done_o   (out_done)
  );

  assign m_axis_tdata = {{(80-RAW_W-WEIGHT_W){1'b0}}, out_weight, out_raw};
  assign m_axis_tuser = {out_done, out_status, out_wvalid};

endmodule

### sv/lcts_checker.sv
// ----------------------------------------------------------------------------
// lcts_checker
// Port-level checks on the load-cell core, bound to the top level.
// ----------------------------------------------------------------------------
module lcts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser
);
  import lcts_pkg::*;

  // one request in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed or dropped");

  // no measured weight means weight field is zero
  a_weight_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[72:24] == '0))
    else $error("weight nonzero without weight_valid");

  // finished average: status ok, no weight; valid weight only with status ok
  a_flag_combo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[3] || m_axis_tuser[0])) |->
      ((m_axis_tuser[2:1] == STATUS_OK) && !(m_axis_tuser[3] && m_axis_tuser[0])))
    else $error("inconsistent weight_valid, status and cal_done");

endmodule

bind load_cell_tare_scale_core lcts_checker u_lcts_checker (.*);

### tb/sv/load_cell_tare_scale_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_tare_scale_core_test
// Self-checking bench for the load-cell tare/scale core. Converter words with
// a mode are streamed in and every result is compared, field by field, with a
// local tare/reference/weight calculation. Tare and reference averages are
// built from full and broken runs around chosen bases, so small, zero and
// negative divisors come up. ref_mass_mg is rewritten over APB between
// phases while the core is drained. The phases cycle through no idling,
// sender gaps, receiver stalls and both.
// ----------------------------------------------------------------------------
module load_cell_tare_scale_core_test;
  import lcts_pkg::*;

  localparam int         CLK_HALF     = 10;
  localparam int         CYCLE_LIMIT  = 1_000_000;
  localparam int         DRAIN_CYCLES = 80;   // longer than one divider pass
  localparam int         RAND_PHASES  = 6;
  localparam int         PHASE_ITEMS  = 275;
  localparam logic [1:0] MODE_SPARE   = 2'd3; // unused code, acts as measure
  localparam logic [2:0] REG_REF_MASS = 3'd0;

  typedef struct packed {
    logic [1:0]       mode;
    logic [RAW_W-1:0] raw;
  } sample_req_t;

  typedef struct {
    logic [RAW_W-1:0]    raw;
    logic [WEIGHT_W-1:0] weight;
    logic                valid;
    status_e             status;
    logic                done;
  } weight_result_t;

  // clock, reset and DUT ports; the inputs are known from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // [23:0] raw_code
  logic [1:0]  s_axis_tuser  = '0;  // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;        // [23:0] signed_raw, [72:24] weight_mg, zero pad
  logic [3:0]  m_axis_tuser;        // [0] weight_valid, [2:1] status, [3] cal_done
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  // stimulus and scoreboard
  sample_req_t    pending_samples[$];
  weight_result_t expected_readings[$];
  int             send_idle_pct  = 0;
  int             recv_stall_pct = 0;
  int             error_count    = 0;
  int             cycle_count    = 0;
  logic           req_taken      = 1'b0;

  // local copy of the core state
  logic [MASS_W-1:0]        mass_cfg_q    = '0;
  logic signed [RAW_W-1:0]  tare_offset_q = '0;
  logic signed [RAW_W-1:0]  ref_reading_q = '0;
  logic signed [SUM_W-1:0]  avg_sum_q     = '0;
  int                       avg_cnt_q     = 0;
  logic [1:0]               avg_mode_q    = MODE_NONE;

  // bases the generator aims its calibration runs at
  logic [RAW_W-1:0] tare_plan = '0;
  logic [RAW_W-1:0] ref_plan  = '0;

  load_cell_tare_scale_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Expected result of one accepted request; updates the local state.
  // --------------------------------------------------------------------------
  function automatic weight_result_t calc_weight(input logic [1:0] mode,
                                                 input logic [RAW_W-1:0] raw);
    weight_result_t r;
    logic signed [RAW_W-1:0] reading;
    longint divisor;
    longint num;
    longint quot;
    reading  = raw;
    r.raw    = raw;
    r.weight = '0;
    r.valid  = 1'b0;
    r.status = STATUS_OK;
    r.done   = 1'b0;
    if (mode == MODE_TARE || mode == MODE_REF) begin
      // a different calibration mode restarts the average
      if (avg_mode_q != mode) begin
        avg_sum_q  = '0;
        avg_cnt_q  = 0;
        avg_mode_q = mode;
      end
      avg_sum_q = avg_sum_q + reading;
      avg_cnt_q++;
      if (avg_cnt_q >= AVG_SAMPLES) begin
        // signed divide truncates toward zero
        if (mode == MODE_TARE) tare_offset_q = RAW_W'(avg_sum_q / AVG_SAMPLES);
        else                   ref_reading_q = RAW_W'(avg_sum_q / AVG_SAMPLES);
        avg_sum_q  = '0;
        avg_cnt_q  = 0;
        avg_mode_q = MODE_NONE;
        r.done     = 1'b1;
      end else begin
        r.status = STATUS_CAL;
      end
    end else begin
      // measure (and the spare code) drops any running average
      avg_sum_q  = '0;
      avg_cnt_q  = 0;
      avg_mode_q = MODE_NONE;
      divisor = longint'(ref_reading_q) - longint'(tare_offset_q);
      if (divisor == 0) begin
        r.status = STATUS_UNCAL;
      end else begin
        num      = (longint'(reading) - longint'(tare_offset_q)) * longint'(mass_cfg_q);
        quot     = num / divisor;
        r.weight = quot[WEIGHT_W-1:0];
        r.valid  = 1'b1;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: request side and result backpressure, changed on falling edges
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    sample_req_t req;
    if (rst_ni) begin
      if (!s_axis_tvalid || req_taken) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = pending_samples.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= req.raw;
          s_axis_tuser  <= req.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: requests go through the calculation, results are checked
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    weight_result_t exp_r;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** load_cell_tare_scale_core: FAILED **");
      $finish;
    end else if (rst_ni) begin
      req_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready)
        expected_readings.push_back(calc_weight(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_readings.size() == 0) begin
          $error("result with nothing expected: tdata %h tuser %h",
                 m_axis_tdata, m_axis_tuser);
          error_count++;
        end else begin
          exp_r = expected_readings.pop_front();
          if (m_axis_tdata[23:0] !== exp_r.raw) begin
            $error("signed_raw: expected %h actual %h", exp_r.raw, m_axis_tdata[23:0]);
            error_count++;
          end
          if (m_axis_tdata[72:24] !== exp_r.weight) begin
            $error("weight_mg: expected %0d actual %0d", $signed(exp_r.weight),
                   $signed(m_axis_tdata[72:24]));
            error_count++;
          end
          if (m_axis_tuser[0] !== exp_r.valid) begin
            $error("weight_valid: expected %b actual %b", exp_r.valid, m_axis_tuser[0]);
            error_count++;
          end
          if (m_axis_tuser[2:1] !== exp_r.status) begin
            $error("status: expected %0d actual %0d", exp_r.status, m_axis_tuser[2:1]);
            error_count++;
          end
          if (m_axis_tuser[3] !== exp_r.done) begin
            $error("cal_done: expected %b actual %b", exp_r.done, m_axis_tuser[3]);
            error_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_req(input logic [1:0] mode, input logic [RAW_W-1:0] raw);
    sample_req_t req;
    req.mode = mode;
    req.raw  = raw;
    pending_samples.push_back(req);
  endtask

  // base word for a calibration run, weighted toward the extremes
  function automatic logic [RAW_W-1:0] pick_word();
    case ($urandom_range(4))
      0:       return 24'h800000;
      1:       return 24'h7FFFFF;
      2:       return 24'h000000;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic int pick_spread();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 3;
      default: return 1000;
    endcase
  endfunction

  // reference base relative to the tare base: zero, unit and wide divisors
  function automatic logic [RAW_W-1:0] pick_ref_base();
    case ($urandom_range(5))
      0:       return tare_plan;
      1:       return tare_plan + 24'd1;
      2:       return tare_plan - 24'd1;
      3:       return tare_plan + 24'($urandom_range(2, 4000));
      4:       return tare_plan - 24'($urandom_range(2, 4000));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] pick_measure();
    case ($urandom_range(3))
      0:       return 24'($urandom);
      1:       return tare_plan + 24'($urandom_range(0, 200)) - 24'd100;
      2:       return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return ref_plan + 24'($urandom_range(0, 200)) - 24'd100;
    endcase
  endfunction

  task automatic add_cal_run(input logic [1:0] mode, input logic [RAW_W-1:0] base,
                             input int spread, input int len);
    repeat (len)
      push_req(mode, base + 24'($urandom_range(0, 2 * spread)) - 24'(spread));
  endtask

  // mostly complete calibrations and measures, some broken runs and noise
  task automatic gen_random(input int n);
    int made;
    int pick;
    int len;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 22) begin
        tare_plan = pick_word();
        add_cal_run(MODE_TARE, tare_plan, pick_spread(), AVG_SAMPLES);
        made += AVG_SAMPLES;
      end else if (pick < 44) begin
        ref_plan = pick_ref_base();
        add_cal_run(MODE_REF, ref_plan, pick_spread(), AVG_SAMPLES);
        made += AVG_SAMPLES;
      end else if (pick < 80) begin
        len = $urandom_range(1, 6);
        repeat (len) push_req(MODE_MEASURE, pick_measure());
        made += len;
      end else if (pick < 90) begin
        len = $urandom_range(1, AVG_SAMPLES - 1);
        add_cal_run($urandom_range(1) ? MODE_TARE : MODE_REF, pick_word(),
                    pick_spread(), len);
        made += len;
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) push_req(2'($urandom_range(3)), 24'($urandom));
        made += len;
      end
    end
  endtask

  // every queued request in, every result out, divider settled
  task automatic wait_drained();
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_readings.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access until pready
  task automatic write_ref_mass(input logic [MASS_W-1:0] mass);
    @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = REG_REF_MASS;
    pwdata  = {8'd0, mass};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    mass_cfg_q = mass;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
      default: begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [MASS_W-1:0] mass;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, uncalibrated start, mode restart, abandoned average
    write_ref_mass(24'hFFFFFF);
    set_idling(0);
    push_req(MODE_MEASURE, 24'h800000);   // offset equals reference after reset
    push_req(MODE_SPARE, 24'h7FFFFF);     // spare code behaves as measure
    push_req(MODE_TARE, 24'h000001);
    push_req(MODE_TARE, 24'hFFFFFF);
    push_req(MODE_TARE, 24'h123456);
    repeat (6) push_req(MODE_REF, 24'h7FFFFF);  // switch restarts the average
    repeat (4) push_req(MODE_REF, 24'h800000);
    push_req(MODE_MEASURE, 24'h7FFFFF);
    push_req(MODE_MEASURE, 24'h800000);
    push_req(MODE_MEASURE, 24'h000000);
    repeat (4) push_req(MODE_TARE, 24'hABCDEF);
    push_req(MODE_MEASURE, 24'h400000);   // drops the partial tare
    wait_drained();

    // random phases, each with its own mass and idling pattern
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       mass = 24'd0;
        1:       mass = 24'hFFFFFF;
        2:       mass = 24'd1;
        3:       mass = 24'($urandom);
        4:       mass = 24'($urandom_range(1, 5000));
        default: mass = 24'd500000;
      endcase
      write_ref_mass(mass);
      set_idling(ph + 1);
      gen_random(PHASE_ITEMS);
      wait_drained();
    end

    if (error_count == 0) begin
      $display("** load_cell_tare_scale_core: PASSED **");
    end else begin
      $display("** load_cell_tare_scale_core: FAILED **");
    end
    $finish;
  end

endmodule
